// ----- rtl/ppt_pkg.sv -----
// Shared types and constants for the pulse-period tachometer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ppt_pkg;

   // Input item commands
   localparam logic CMD_PULSE = 1'b0;
   localparam logic CMD_POLL  = 1'b1;

   // Register map (index = byte address / 4)
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_MAX_AGE = 2'd0;
   localparam logic [1:0] REG_PPR     = 2'd1;
   localparam logic [1:0] REG_CIRC    = 2'd2;

   localparam logic [15:0] MAX_AGE_RESET = 16'd2000;
   localparam logic [6:0]  PPR_RESET     = 7'd1;
   localparam logic [23:0] CIRC_RESET    = 24'd16777;

   // Divider geometry: 26-bit dividend covers the microseconds per minute
   localparam int DIV_W     = 26;
   localparam int DVS_W     = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam logic [DIV_W-1:0] US_PER_MIN = 26'd60000000;

   localparam logic [15:0] RPM_MAX = 16'hFFFF;
   localparam int RPM60_W = 22;
   localparam int PROD_W  = RPM60_W + 24;

   typedef struct packed {
      logic [15:0] max_age_ms;
      logic [6:0]  pulses_per_rev;
      logic [23:0] circumference_miles;
   } ppt_cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } ppt_div_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_NUM,
      ST_DIV_RPM,
      ST_SCALE,
      ST_MULT,
      ST_FINISH
   } ppt_state_type;

endpackage

`default_nettype wire

// ----- rtl/ppt_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on ppt_pkg for the register map and the config struct.
`default_nettype none

module ppt_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ppt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ppt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ppt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                               csr_pready,
   output ppt_pkg::ppt_cfg_type               cfg
);
   import ppt_pkg::*;

   ppt_cfg_type cfg_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_age_ms          <= MAX_AGE_RESET;
         cfg_ff.pulses_per_rev      <= PPR_RESET;
         cfg_ff.circumference_miles <= CIRC_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MAX_AGE: cfg_ff.max_age_ms          <= csr_pwdata[15:0];
            REG_PPR:     cfg_ff.pulses_per_rev      <= csr_pwdata[6:0];
            REG_CIRC:    cfg_ff.circumference_miles <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAX_AGE: csr_prdata = {16'd0, cfg_ff.max_age_ms};
         REG_PPR:     csr_prdata = {25'd0, cfg_ff.pulses_per_rev};
         REG_CIRC:    csr_prdata = {8'd0, cfg_ff.circumference_miles};
         default:     csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/ppt_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, shared by both divisions.
// Depends on ppt_pkg for widths and the request struct.
`default_nettype none

module ppt_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  ppt_pkg::ppt_div_req_type       div_req,
   output logic                           busy,
   output logic                           done,
   output logic [ppt_pkg::DIV_W-1:0]      quotient
);
   import ppt_pkg::*;

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 done_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W:0]       trial;
   logic                 fits;
   logic [DVS_W:0]       diff;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == DIV_CNT_W'(1));
         if (div_req.start) begin
            cnt_ff <= DIV_CNT_W'(DIV_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   // Dividend bits shift out of quo_ff as quotient bits shift in
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy)
      else $error("divider restarted while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == DIV_CNT_W'(1)) |=> done)
      else $error("divider done missing after last step");

endmodule

`default_nettype wire

// ----- rtl/pulse_period_tachometer_unit.sv -----
// Top level of the pulse-period tachometer: sequencer, state and speed multiplier.
// Depends on ppt_pkg, ppt_csr and ppt_divider.
`default_nettype none

// One item at a time. A poll or a stale pulse passes through the eval, scale,
// multiply and finish states; a pulse that updates the rpm also makes two passes
// through the shared 26-step divider (60000000 / pulses_per_rev, then that
// quotient / average interval, skipped when that is zero) before the speed multiply.
// req_ready is high only while the sequencer is idle; a finished result sits in
// the output register until taken, and the next item is accepted meanwhile.
module pulse_period_tachometer_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_command,
   input  wire logic [31:0]                    req_now_ms,
   input  wire logic [31:0]                    req_now_us,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [15:0]                    rsp_rpm,
   output logic      [15:0]                    rsp_speed_mph,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ppt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ppt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [ppt_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ppt_pkg::*;

   ppt_cfg_type     cfg;
   ppt_div_req_type div_req;
   logic            div_busy;
   logic            div_done;
   logic [DIV_W-1:0] div_quo;

   ppt_state_type state_ff, state_in;

   logic        cmd_ff;
   logic [31:0] ms_ff;
   logic [31:0] us_ff;
   logic [31:0] last_us_ff;
   logic [31:0] last_ms_ff;
   logic [31:0] ivl0_ff;
   logic [31:0] ivl1_ff;
   logic [15:0] rpm_value_ff;
   logic        poll_zero_ff;
   logic [15:0] rpm_out_ff;
   logic [RPM60_W-1:0] rpm60_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_rpm_ff;
   logic [15:0] rsp_speed_ff;

   logic [31:0] age;
   logic        age_over;
   logic        pulse_stale;
   logic        can_update;
   logic [32:0] ivl_sum;
   logic [31:0] avg;
   logic [6:0]  ppr_eff;
   logic [15:0] rpm_sat;
   logic [15:0] rpm_sel;
   logic [15:0] speed_sat;
   logic        out_free;

   ppt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ppt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign age         = ms_ff - last_ms_ff;
   assign age_over    = age > {16'd0, cfg.max_age_ms};
   assign pulse_stale = age_over;
   assign can_update  = (last_us_ff != '0) && (last_us_ff < us_ff);
   assign ivl_sum     = {1'b0, ivl0_ff} + {1'b0, ivl1_ff};
   assign avg         = ivl_sum[32:1];
   assign ppr_eff     = (cfg.pulses_per_rev == '0) ? 7'd1 : cfg.pulses_per_rev;
   assign rpm_sat     = (div_quo[DIV_W-1:16] != '0) ? RPM_MAX : div_quo[15:0];
   assign rpm_sel     = (cmd_ff == CMD_POLL && poll_zero_ff) ? 16'd0 : rpm_value_ff;
   assign speed_sat   = (prod_ff[PROD_W-1:32] != '0) ? RPM_MAX : prod_ff[31:16];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (cmd_ff == CMD_PULSE && !pulse_stale && can_update) state_in = ST_DIV_NUM;
            else state_in = ST_SCALE;
         end
         ST_DIV_NUM: begin
            if (div_done) state_in = (avg == '0) ? ST_SCALE : ST_DIV_RPM;
         end
         ST_DIV_RPM: begin
            if (div_done) state_in = ST_SCALE;
         end
         ST_SCALE:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready        = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = US_PER_MIN;
      div_req.divisor  = {{(DVS_W-7){1'b0}}, ppr_eff};
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EVAL: begin
            div_req.start = (cmd_ff == CMD_PULSE) && !pulse_stale && can_update;
         end
         ST_DIV_NUM: begin
            div_req.dividend = div_quo;
            div_req.divisor  = avg;
            div_req.start    = div_done && (avg != '0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_us_ff   <= '0;
         last_ms_ff   <= '0;
         ivl0_ff      <= '0;
         ivl1_ff      <= '0;
         rpm_value_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EVAL && cmd_ff == CMD_PULSE) begin
            last_ms_ff <= ms_ff;
            if (pulse_stale) begin
               rpm_value_ff <= '0;
               last_us_ff   <= '0;
            end else begin
               ivl0_ff    <= ivl1_ff;
               ivl1_ff    <= us_ff - last_us_ff;
               last_us_ff <= us_ff;
            end
         end
         if (state_ff == ST_DIV_NUM && div_done && avg == '0) begin
            rpm_value_ff <= RPM_MAX;
         end
         if (state_ff == ST_DIV_RPM && div_done) begin
            rpm_value_ff <= rpm_sat;
         end
         if (state_ff == ST_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         cmd_ff <= req_command;
         ms_ff  <= req_now_ms;
         us_ff  <= req_now_us;
      end
      if (state_ff == ST_EVAL) begin
         poll_zero_ff <= (ms_ff > last_ms_ff) && age_over;
      end
      if (state_ff == ST_SCALE) begin
         rpm_out_ff <= rpm_sel;
         // rpm * 60 as (rpm * 64) - (rpm * 4)
         rpm60_ff   <= {rpm_sel, 6'd0} - {4'd0, rpm_sel, 2'd0};
      end
      if (state_ff == ST_MULT) begin
         prod_ff <= PROD_W'(rpm60_ff) * PROD_W'(cfg.circumference_miles);
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_rpm_ff   <= rpm_out_ff;
         rsp_speed_ff <= speed_sat;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rpm       = rsp_rpm_ff;
   assign rsp_speed_mph = rsp_speed_ff;

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("divider busy while accepting an item");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_NUM || state_ff == ST_DIV_RPM))
      else $error("divider finished outside a division state");

   a_pulse_rpm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && cmd_ff == CMD_PULSE) |-> rpm_out_ff == rpm_value_ff)
      else $error("pulse result rpm differs from stored rpm");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid && state_ff == ST_IDLE)
      else $error("finished item not presented");

endmodule

`default_nettype wire

// ----- tb/ppt_reading_checker.sv -----
// Scoreboard for the pulse-period tachometer: tracks register writes, predicts
// rpm and speed for every accepted item and compares each taken reading.
// Depends on ppt_pkg.
module ppt_reading_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic                           req_command,
   input  wire logic [31:0]                    req_now_ms,
   input  wire logic [31:0]                    req_now_us,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire logic [15:0]                    rsp_rpm,
   input  wire logic [15:0]                    rsp_speed_mph,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ppt_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [ppt_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                           csr_pready,
   output int                                  mismatch_count,
   output int                                  readings_pending
);
   import ppt_pkg::*;

   localparam logic [31:0] MICROS_PER_MINUTE = 32'd60_000_000;
   localparam logic [15:0] SAT16             = 16'hFFFF;

   typedef struct packed {
      logic [15:0] rpm;
      logic [15:0] speed_mph;
   } reading_type;

   reading_type expected_readings[$];
   ppt_cfg_type cfg;
   logic [31:0] last_us;
   logic [31:0] last_ms;
   logic [31:0] older_interval;
   logic [31:0] newer_interval;
   logic [15:0] held_rpm;

   function automatic logic [15:0] speed_for(input logic [15:0] rpm);
      logic [63:0] rpm_w;
      logic [63:0] circ_w;
      logic [63:0] prod;
      rpm_w  = rpm;
      circ_w = cfg.circumference_miles;
      prod   = (rpm_w * 64'd60 * circ_w) >> 16;
      return (prod > 64'hFFFF) ? SAT16 : prod[15:0];
   endfunction

   function automatic void apply_pulse(input logic [31:0] ms, input logic [31:0] us);
      logic [31:0] since;
      logic [31:0] per_rev;
      logic [31:0] numerator;
      logic [32:0] avg;
      logic [32:0] quotient;
      since = ms - last_ms;
      if (since > {16'd0, cfg.max_age_ms}) begin
         // wheel stopped: forget the rpm and the last edge time
         held_rpm = '0;
         last_us  = '0;
      end else begin
         older_interval = newer_interval;
         newer_interval = us - last_us;
         avg = ({1'b0, older_interval} + {1'b0, newer_interval}) >> 1;
         if (last_us != 0 && last_us < us) begin
            per_rev   = (cfg.pulses_per_rev == 0) ? 32'd1 : {25'd0, cfg.pulses_per_rev};
            numerator = MICROS_PER_MINUTE / per_rev;
            if (avg == 0) begin
               held_rpm = SAT16;
            end else begin
               quotient = {1'b0, numerator} / avg;
               held_rpm = (quotient > 33'hFFFF) ? SAT16 : quotient[15:0];
            end
         end
         last_us = us;
      end
      last_ms = ms;
   endfunction

   function automatic reading_type predict_reading(input logic cmd, input logic [31:0] ms,
                                                   input logic [31:0] us);
      reading_type r;
      if (cmd == CMD_PULSE) begin
         apply_pulse(ms, us);
         r.rpm = held_rpm;
      end else begin
         r.rpm = held_rpm;
         if (ms > last_ms && (ms - last_ms) > {16'd0, cfg.max_age_ms})
            r.rpm = '0;
      end
      r.speed_mph = speed_for(r.rpm);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reading_type want;
      if (reset) begin
         cfg.max_age_ms          = MAX_AGE_RESET;
         cfg.pulses_per_rev      = PPR_RESET;
         cfg.circumference_miles = CIRC_RESET;
         last_us        = '0;
         last_ms        = '0;
         older_interval = '0;
         newer_interval = '0;
         held_rpm       = '0;
         expected_readings.delete();
      end else begin
         // the reading taken here belongs to an earlier item, so check before pushing
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected reading: rpm %0d speed_mph %0d", rsp_rpm, rsp_speed_mph);
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_rpm !== want.rpm) begin
                  $error("rpm mismatch: expected %0d, got %0d", want.rpm, rsp_rpm);
                  mismatch_count++;
               end
               if (rsp_speed_mph !== want.speed_mph) begin
                  $error("speed_mph mismatch: expected %0d, got %0d",
                         want.speed_mph, rsp_speed_mph);
                  mismatch_count++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_MAX_AGE: cfg.max_age_ms          = csr_pwdata[15:0];
               REG_PPR:     cfg.pulses_per_rev      = csr_pwdata[6:0];
               REG_CIRC:    cfg.circumference_miles = csr_pwdata[23:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_readings.push_back(predict_reading(req_command, req_now_ms, req_now_us));
      end
      readings_pending = expected_readings.size();
   end

endmodule

// ----- tb/tb_pulse_period_tachometer_unit.sv -----
// Testbench top for pulse_period_tachometer_unit: clock, reset, register writes,
// pulse and poll stimulus with random idling, and the verdict.
// Depends on ppt_pkg, the block and ppt_reading_checker.
module tb_pulse_period_tachometer_unit;
   import ppt_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int STALL_CYCLES  = 400;
   localparam int PHASE_ITEMS   = 400;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_command   = CMD_PULSE;
   logic [31:0]           req_now_ms    = '0;
   logic [31:0]           req_now_us    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [15:0]           rsp_rpm;
   logic [15:0]           rsp_speed_mph;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          mismatch_count;
   int          readings_pending;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          stall_token   = 0;
   int          stall_seen    = 0;
   int          stall_left    = 0;
   int          cycle_count   = 0;
   int unsigned age_ms        = 2000;
   logic [31:0] wheel_ms      = '0;
   logic [31:0] wheel_us      = '0;

   pulse_period_tachometer_unit u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_now_ms    (req_now_ms),
      .req_now_us    (req_now_us),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rpm       (rsp_rpm),
      .rsp_speed_mph (rsp_speed_mph),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   ppt_reading_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_now_ms       (req_now_ms),
      .req_now_us       (req_now_us),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rpm          (rsp_rpm),
      .rsp_speed_mph    (rsp_speed_mph),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL pulse_period_tachometer_unit");
         $finish;
      end
   end

   // reading side: random back-pressure, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_token != stall_seen) begin
         stall_seen <= stall_token;
         stall_left <= STALL_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // valid is only lowered when a gap follows, so it never drops and rises in one step
   task automatic send_item(input logic cmd, input logic [31:0] ms, input logic [31:0] us);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_now_ms  <= ms;
      req_now_us  <= us;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly a turning wheel with coherent timestamps; some stops, glitches and noise
   task automatic random_item();
      int unsigned pick;
      int unsigned step_us;
      logic [31:0] us;
      pick = $urandom_range(99);
      if (pick < 6) begin
         send_item(1'($urandom_range(1)), $urandom, $urandom);
      end else if (pick < 30) begin
         pick = $urandom_range(9);
         if (pick == 0) begin
            wheel_ms += age_ms + 1 + $urandom_range(5000);
            send_item(CMD_POLL, wheel_ms, $urandom);
         end else if (pick == 1) begin
            send_item(CMD_POLL, wheel_ms - $urandom_range(1, 100), $urandom);
         end else begin
            wheel_ms += $urandom_range(age_ms / 4);
            send_item(CMD_POLL, wheel_ms, $urandom);
         end
      end else begin
         if ($urandom_range(3) == 0)
            step_us = $urandom_range(2000);
         else
            step_us = $urandom_range(age_ms * 1000);
         wheel_us += step_us;
         wheel_ms += step_us / 1000;
         us = wheel_us;
         pick = $urandom_range(99);
         if (pick < 5) begin
            wheel_ms += age_ms + 1 + $urandom_range(10000);
         end else if (pick < 9) begin
            us = wheel_us - $urandom_range(1, 5000);
         end else if (pick < 11) begin
            us       = '0;
            wheel_us = '0;
         end
         send_item(CMD_PULSE, wheel_ms, us);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset register values
      send_item(CMD_POLL,  32'd0,  32'd0);
      send_item(CMD_PULSE, 32'd10, 32'd0);       // previous us is zero: no update
      send_item(CMD_PULSE, 32'd11, 32'd1000);
      send_item(CMD_PULSE, 32'd12, 32'd1001);    // quotient above 16 bits
      send_item(CMD_PULSE, 32'd12, 32'd1002);
      send_item(CMD_PULSE, 32'd12, 32'd1002);    // same us: no update, zero interval
      send_item(CMD_PULSE, 32'd12, 32'd1003);    // average rounds to zero
      send_item(CMD_PULSE, 32'd30, 32'd21003);   // speed saturates
      send_item(CMD_POLL,  32'd500, 32'hFFFF_FFFF);
      send_item(CMD_POLL,  32'd2031, 32'd0);     // stale poll
      send_item(CMD_POLL,  32'd5, 32'd0);        // ms behind last pulse: not stale
      send_item(CMD_PULSE, 32'd5000, 32'd9_999_999); // stale pulse clears rpm
      send_item(CMD_PULSE, 32'd5001, 32'hFFFF_FFFF);
      send_item(CMD_PULSE, 32'd5002, 32'd100);   // us went backward, interval wraps
      send_item(CMD_PULSE, 32'd5003, 32'hFFFF_FFFF); // interval sum carries past 32 bits
      send_item(CMD_PULSE, 32'hFFFF_FFF0, 32'd500);
      send_item(CMD_PULSE, 32'd5, 32'd1500);     // ms wrapped, not stale
      send_item(CMD_PULSE, 32'd6, 32'd2500);
      send_item(CMD_POLL,  32'd10, 32'd0);
      send_item(CMD_POLL,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      csr_write(REG_MAX_AGE, 32'd65535);
      csr_write(REG_PPR, 32'd0);                 // zero pulses per rev acts as one
      csr_write(REG_CIRC, 32'd0);
      age_ms        = 65535;
      send_idle_pct = 38;
      recv_idle_pct = 85;
      repeat (PHASE_ITEMS) random_item();
      drain();

      csr_write(REG_MAX_AGE, 32'd1);
      csr_write(REG_PPR, 32'd64);
      csr_write(REG_CIRC, 32'h00FF_FFFF);
      age_ms        = 1;
      send_idle_pct = 85;
      recv_idle_pct = 38;
      repeat (PHASE_ITEMS) random_item();
      drain();

      age_ms = $urandom_range(1, 5000);
      csr_write(REG_MAX_AGE, age_ms);
      csr_write(REG_PPR, $urandom_range(1, 64));
      csr_write(REG_CIRC, $urandom_range(24'hFF_FFFF));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_token  <= stall_token + 1;
      repeat (PHASE_ITEMS) random_item();
      drain();

      if (mismatch_count == 0) begin
         $display("PASS pulse_period_tachometer_unit");
      end else begin
         $display("FAIL pulse_period_tachometer_unit");
      end
      $finish;
   end

endmodule
